// ===== rtl/lpmd_pkg.sv =====
package lpmd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int RING_BYTES   = 262144;
    localparam int READY_SLOTS  = 64;

    localparam int RING_AW  = $clog2(RING_BYTES);
    localparam int SLOT_AW  = $clog2(READY_SLOTS);
    localparam int HCNT_W   = $clog2(HEADER_BYTES + 1);

    localparam int LEN_W    = 17;
    localparam int QBYTES_W = 19;
    localparam int NMSG_W   = 7;
    localparam int CFG_W    = 19;

    localparam logic [LEN_W-1:0]    RST_MAX_LEN    = LEN_W'(4096);
    localparam logic [QBYTES_W-1:0] RST_MAX_QBYTES = QBYTES_W'(65536);
    localparam logic [NMSG_W-1:0]   RST_MAX_MSGS   = NMSG_W'(64);

    localparam logic [QBYTES_W-1:0] RING_CAP  = QBYTES_W'(RING_BYTES);
    localparam logic [NMSG_W-1:0]   SLOT_CAP  = NMSG_W'(READY_SLOTS);

    typedef enum logic [1:0] {
        OP_FEED   = 2'd0,
        OP_READ   = 2'd1,
        OP_FINISH = 2'd2,
        OP_CANCEL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_MAX_LEN    = 2'd0,
        REG_MAX_QBYTES = 2'd1,
        REG_MAX_MSGS   = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        ST_ACCEPTED     = 4'd0,
        ST_BACKPRESSURE = 4'd1,
        ST_INVALID      = 4'd2,
        ST_CLOSED       = 4'd3,
        ST_BYTE_OUT     = 4'd4,
        ST_EMPTY        = 4'd5,
        ST_FINISH_OK    = 4'd6,
        ST_FINISH_FAIL  = 4'd7,
        ST_CANCELLED    = 4'd8
    } t_status;

endpackage

// ===== rtl/length_prefixed_message_deframer.sv =====
// Length-prefixed message deframer.
// The slave stream carries one operation per item: tuser selects feed, read,
// finish or cancel, and tdata carries the stream byte for a feed. Fed bytes
// form messages of a four-byte big-endian length followed by the body.
// Completed bodies are stored in a byte ring memory and their lengths in a
// length queue memory. Every item produces exactly one result item on the
// master stream: tuser is the status, tdata the delivered byte for a read,
// and tlast marks the final byte of a message.
// An item is taken in every cycle unless a held result is stalled; its
// result appears in the cycle after acceptance, with the read byte from
// the registered read of the byte ring. The output register is the only
// buffer: while the receiver stalls, one result is held and the input
// accepts a new item in the cycle the held result is taken. Reset empties
// the stream, opens it, and loads the default limits; the memories need no
// clearing. Limits must be written on the configuration channel only while
// the block is idle, which it does not enforce; the channel is always ready.
module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // data_byte
    input  logic [1:0]        s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // out_byte
    output logic [3:0]        m_axis_tuser,   // status
    output logic              m_axis_tlast,   // message_last
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0]    r_max_len;
    logic [QBYTES_W-1:0] r_max_qbytes;
    logic [NMSG_W-1:0]   r_max_msgs;

    logic [31:0]         r_hshift, n_hshift;
    logic [HCNT_W-1:0]   r_hcount, n_hcount;
    logic [LEN_W-1:0]    r_exp_len, n_exp_len;
    logic [LEN_W-1:0]    r_body_cnt, n_body_cnt;
    logic                r_closed, n_closed;
    logic [NMSG_W-1:0]   r_ready_cnt, n_ready_cnt;
    logic [QBYTES_W-1:0] r_qtotal, n_qtotal;
    logic [RING_AW-1:0]  r_wp, n_wp;
    logic [RING_AW-1:0]  r_rp, n_rp;
    logic [LEN_W-1:0]    r_roff, n_roff;
    logic [SLOT_AW-1:0]  r_qhead, n_qhead;
    logic [SLOT_AW-1:0]  r_qtail, n_qtail;
    logic [LEN_W-1:0]    r_head_len, n_head_len;

    logic                r_out_valid;
    logic [3:0]          r_out_status;
    logic                r_out_last, r_out_isbyte;

    logic                accept;
    t_op                 op;
    t_status             status;
    logic                last, isbyte;
    logic [NMSG_W-1:0]   cap_msgs;
    logic [QBYTES_W-1:0] cap_bytes, free_bytes;
    logic [31:0]         hnew;

    logic                ring_we, ring_re;
    logic [7:0]          ring_q;
    logic                len_we;
    logic [SLOT_AW-1:0]  len_raddr;
    logic [LEN_W-1:0]    len_q, len_next;
    logic                r_fwd_hit;
    logic [LEN_W-1:0]    r_fwd_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = t_op'(s_axis_tuser);
    assign o_cfg_ready   = 1'b1;

    assign cap_msgs   = (r_max_msgs < SLOT_CAP) ? r_max_msgs : SLOT_CAP;
    assign cap_bytes  = (r_max_qbytes < RING_CAP) ? r_max_qbytes : RING_CAP;
    assign free_bytes = (r_qtotal < cap_bytes) ? cap_bytes - r_qtotal : '0;
    assign hnew       = {r_hshift[23:0], s_axis_tdata};
    assign len_next   = r_fwd_hit ? r_fwd_data : len_q;

    always_comb begin
        n_hshift    = r_hshift;
        n_hcount    = r_hcount;
        n_exp_len   = r_exp_len;
        n_body_cnt  = r_body_cnt;
        n_closed    = r_closed;
        n_ready_cnt = r_ready_cnt;
        n_qtotal    = r_qtotal;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_roff      = r_roff;
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_head_len  = r_head_len;
        status      = ST_ACCEPTED;
        last        = 1'b0;
        isbyte      = 1'b0;
        ring_we     = 1'b0;
        ring_re     = 1'b0;
        len_we      = 1'b0;
        unique case (op)
            OP_FEED: begin
                priority if (r_closed) begin
                    status = ST_CLOSED;
                end else if (r_ready_cnt >= cap_msgs) begin
                    status = ST_BACKPRESSURE;
                end else if (r_hcount < HCNT_W'(HEADER_BYTES)) begin
                    n_hshift = hnew;
                    n_hcount = r_hcount + 1'b1;
                    if (r_hcount == HCNT_W'(HEADER_BYTES - 1)) begin
                        if (hnew == '0 || hnew > {{(32-LEN_W){1'b0}}, r_max_len}) begin
                            status      = ST_INVALID;
                            n_closed    = 1'b1;
                            n_hshift    = '0;
                            n_hcount    = '0;
                            n_exp_len   = '0;
                            n_body_cnt  = '0;
                            n_ready_cnt = '0;
                            n_qtotal    = '0;
                            n_wp        = '0;
                            n_rp        = '0;
                            n_roff      = '0;
                            n_qhead     = '0;
                            n_qtail     = '0;
                        end else begin
                            n_exp_len = hnew[LEN_W-1:0];
                        end
                    end
                end else if ({{(QBYTES_W-LEN_W){1'b0}}, r_exp_len} > free_bytes) begin
                    status = ST_BACKPRESSURE;
                end else begin
                    ring_we    = 1'b1;
                    n_wp       = r_wp + 1'b1;
                    n_body_cnt = r_body_cnt + 1'b1;
                    if (r_body_cnt + 1'b1 >= r_exp_len) begin
                        len_we      = 1'b1;
                        n_qtail     = r_qtail + 1'b1;
                        n_ready_cnt = r_ready_cnt + 1'b1;
                        n_qtotal    = r_qtotal + {{(QBYTES_W-LEN_W){1'b0}}, r_exp_len};
                        if (r_ready_cnt == '0) begin
                            n_head_len = r_exp_len;
                        end
                        n_hshift   = '0;
                        n_hcount   = '0;
                        n_exp_len  = '0;
                        n_body_cnt = '0;
                    end
                end
            end
            OP_READ: begin
                if (r_ready_cnt == '0) begin
                    status = ST_EMPTY;
                end else begin
                    status  = ST_BYTE_OUT;
                    isbyte  = 1'b1;
                    ring_re = 1'b1;
                    n_rp    = r_rp + 1'b1;
                    n_roff  = r_roff + 1'b1;
                    if (r_roff + 1'b1 >= r_head_len) begin
                        last        = 1'b1;
                        n_roff      = '0;
                        n_qhead     = r_qhead + 1'b1;
                        n_ready_cnt = r_ready_cnt - 1'b1;
                        n_head_len  = len_next;
                        n_qtotal    = (r_qtotal >= {{(QBYTES_W-LEN_W){1'b0}}, r_head_len})
                                    ? r_qtotal - {{(QBYTES_W-LEN_W){1'b0}}, r_head_len}
                                    : '0;
                    end
                end
            end
            OP_FINISH: begin
                priority if (r_closed) begin
                    status = ST_FINISH_FAIL;
                end else if (r_hcount != '0 || r_body_cnt != '0) begin
                    status      = ST_FINISH_FAIL;
                    n_closed    = 1'b1;
                    n_hshift    = '0;
                    n_hcount    = '0;
                    n_exp_len   = '0;
                    n_body_cnt  = '0;
                    n_ready_cnt = '0;
                    n_qtotal    = '0;
                    n_wp        = '0;
                    n_rp        = '0;
                    n_roff      = '0;
                    n_qhead     = '0;
                    n_qtail     = '0;
                end else begin
                    status   = ST_FINISH_OK;
                    n_closed = 1'b1;
                end
            end
            OP_CANCEL: begin
                status      = ST_CANCELLED;
                n_closed    = 1'b1;
                n_hshift    = '0;
                n_hcount    = '0;
                n_exp_len   = '0;
                n_body_cnt  = '0;
                n_ready_cnt = '0;
                n_qtotal    = '0;
                n_wp        = '0;
                n_rp        = '0;
                n_roff      = '0;
                n_qhead     = '0;
                n_qtail     = '0;
            end
            default: begin
                status = ST_CANCELLED;
            end
        endcase
    end

    // The length memory always fetches the entry behind the head, so the
    // next message length is ready when the head message is released.
    assign len_raddr = (accept ? n_qhead : r_qhead) + 1'b1;

    lpmd_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && ring_we),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata),
        .i_re    (accept && ring_re),
        .i_raddr (r_rp),
        .o_rdata (ring_q)
    );

    lpmd_ram #(.WIDTH(LEN_W), .DEPTH(READY_SLOTS)) u_lenq (
        .i_clk   (i_clk),
        .i_we    (accept && len_we),
        .i_waddr (r_qtail),
        .i_wdata (r_exp_len),
        .i_re    (1'b1),
        .i_raddr (len_raddr),
        .o_rdata (len_q)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_hit  <= accept && len_we && (r_qtail == len_raddr);
        r_fwd_data <= r_exp_len;
        if (accept) begin
            r_out_status <= status;
            r_out_last   <= last;
            r_out_isbyte <= isbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= RST_MAX_LEN;
            r_max_qbytes <= RST_MAX_QBYTES;
            r_max_msgs   <= RST_MAX_MSGS;
            r_hshift     <= '0;
            r_hcount     <= '0;
            r_exp_len    <= '0;
            r_body_cnt   <= '0;
            r_closed     <= 1'b0;
            r_ready_cnt  <= '0;
            r_qtotal     <= '0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_roff       <= '0;
            r_qhead      <= '0;
            r_qtail      <= '0;
            r_head_len   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_MAX_LEN:    r_max_len    <= i_cfg_data[LEN_W-1:0];
                    REG_MAX_QBYTES: r_max_qbytes <= i_cfg_data[QBYTES_W-1:0];
                    REG_MAX_MSGS:   r_max_msgs   <= i_cfg_data[NMSG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_hshift    <= n_hshift;
                r_hcount    <= n_hcount;
                r_exp_len   <= n_exp_len;
                r_body_cnt  <= n_body_cnt;
                r_closed    <= n_closed;
                r_ready_cnt <= n_ready_cnt;
                r_qtotal    <= n_qtotal;
                r_wp        <= n_wp;
                r_rp        <= n_rp;
                r_roff      <= n_roff;
                r_qhead     <= n_qhead;
                r_qtail     <= n_qtail;
                r_head_len  <= n_head_len;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = r_out_isbyte ? ring_q : 8'd0;

endmodule

// ===== rtl/lpmd_ram.sv =====
module lpmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import lpmd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5000000;

    typedef struct {
        t_status    st;
        logic [7:0] b;
        logic       last;
    } t_result;

    class deframer_predictor;
        logic [LEN_W-1:0]    max_len;
        logic [QBYTES_W-1:0] max_qbytes;
        logic [NMSG_W-1:0]   max_msgs;
        logic [31:0]         hdr_shift;
        int unsigned         hdr_cnt, exp_len, body_cnt, rd_off;
        int unsigned         n_ready, q_total, wr_ptr, rd_ptr, q_head, q_tail;
        bit                  closed;
        logic [7:0]          ring[RING_BYTES];
        int unsigned         lens[READY_SLOTS];
        t_result             expected_q[$];
        int                  mismatches;
        int                  n_checked;

        function new();
            max_len    = RST_MAX_LEN;
            max_qbytes = RST_MAX_QBYTES;
            max_msgs   = RST_MAX_MSGS;
            clear_all();
            closed     = 0;
            mismatches = 0;
            n_checked  = 0;
        endfunction

        function void clear_all();
            closed    = 1;
            hdr_shift = 0;
            hdr_cnt   = 0;
            exp_len   = 0;
            body_cnt  = 0;
            n_ready   = 0;
            q_total   = 0;
            wr_ptr    = 0;
            rd_ptr    = 0;
            rd_off    = 0;
            q_head    = 0;
            q_tail    = 0;
        endfunction

        function void write_reg(t_reg idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_MAX_LEN:    max_len    = v[LEN_W-1:0];
                REG_MAX_QBYTES: max_qbytes = v[QBYTES_W-1:0];
                REG_MAX_MSGS:   max_msgs   = v[NMSG_W-1:0];
                default: ;
            endcase
        endfunction

        function t_status feed(logic [7:0] b);
            int unsigned cap_m, cap_b, free_b;
            if (closed) return ST_CLOSED;
            cap_m = (max_msgs < READY_SLOTS) ? max_msgs : READY_SLOTS;
            if (n_ready >= cap_m) return ST_BACKPRESSURE;
            if (hdr_cnt < HEADER_BYTES) begin
                hdr_shift = {hdr_shift[23:0], b};
                hdr_cnt++;
                if (hdr_cnt == HEADER_BYTES) begin
                    if (hdr_shift == 0 || hdr_shift > max_len) begin
                        clear_all();
                        return ST_INVALID;
                    end
                    exp_len = hdr_shift;
                end
                return ST_ACCEPTED;
            end
            cap_b  = (max_qbytes < RING_BYTES) ? max_qbytes : RING_BYTES;
            free_b = (q_total < cap_b) ? cap_b - q_total : 0;
            if (exp_len > free_b) return ST_BACKPRESSURE;
            ring[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % RING_BYTES;
            body_cnt++;
            if (body_cnt >= exp_len) begin
                lens[q_tail] = exp_len;
                q_tail = (q_tail + 1) % READY_SLOTS;
                n_ready++;
                q_total += exp_len;
                hdr_shift = 0;
                hdr_cnt   = 0;
                exp_len   = 0;
                body_cnt  = 0;
            end
            return ST_ACCEPTED;
        endfunction

        function t_status note_item(t_op op, logic [7:0] b);
            t_result r;
            r.b    = 8'd0;
            r.last = 1'b0;
            case (op)
                OP_FEED: r.st = feed(b);
                OP_READ: begin
                    if (n_ready == 0) begin
                        r.st = ST_EMPTY;
                    end else begin
                        r.st = ST_BYTE_OUT;
                        r.b  = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % RING_BYTES;
                        rd_off++;
                        if (rd_off >= lens[q_head]) begin
                            r.last  = 1'b1;
                            rd_off  = 0;
                            q_total = (q_total >= lens[q_head]) ? q_total - lens[q_head] : 0;
                            q_head  = (q_head + 1) % READY_SLOTS;
                            n_ready--;
                        end
                    end
                end
                OP_FINISH: begin
                    if (closed) begin
                        r.st = ST_FINISH_FAIL;
                    end else if (hdr_cnt != 0 || body_cnt != 0) begin
                        clear_all();
                        r.st = ST_FINISH_FAIL;
                    end else begin
                        closed = 1;
                        r.st = ST_FINISH_OK;
                    end
                end
                default: begin
                    clear_all();
                    r.st = ST_CANCELLED;
                end
            endcase
            expected_q.push_back(r);
            return r.st;
        endfunction

        function void check_result(logic [3:0] st, logic [7:0] b, logic last);
            t_result r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d byte %02h last %0b", st, b, last);
                return;
            end
            r = expected_q[0];
            expected_q.delete(0);
            n_checked++;
            if (st !== r.st || b !== r.b || last !== r.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d byte %02h last %0b, got %0d %02h %0b",
                             r.st, r.b, r.last, st, b, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'd0;
    logic [1:0]        s_axis_tuser = OP_FEED;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic [3:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = REG_MAX_LEN;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    deframer_predictor model = new();
    int  n_items = 0;
    int  n_msgs = 0;
    int  n_cycles = 0;
    int  stall_left = 0;
    bit  no_gaps = 0;
    bit  stim_done = 0;

    length_prefixed_message_deframer i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            model.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_gaps && !stim_done)
                stall_left <= pick_gap();
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] b, output t_status st);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        st = model.note_item(op, b);
        n_items++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model.write_reg(idx, v);
    endtask

    task automatic set_limits(input int ml, input int qb, input int nm);
        wait_idle();
        write_reg(REG_MAX_LEN, CFG_W'(ml));
        write_reg(REG_MAX_QBYTES, CFG_W'(qb));
        write_reg(REG_MAX_MSGS, CFG_W'(nm));
        i_cfg_valid <= 1'b0;
    endtask

    // Header bytes go out big-endian; a refused byte is retried after a read.
    task automatic feed_message(input int unsigned len, input int read_pct);
        t_status st;
        logic [7:0] b;
        for (int unsigned i = 0; i < len + HEADER_BYTES; i++) begin
            b = (i < HEADER_BYTES) ? 8'(len >> (8 * (HEADER_BYTES - 1 - i))) : 8'($urandom);
            if ($urandom_range(0, 99) < read_pct) send_item(OP_READ, 8'($urandom), st);
            send_item(OP_FEED, b, st);
            while (st == ST_BACKPRESSURE) begin
                send_item(OP_READ, 8'($urandom), st);
                send_item(OP_FEED, b, st);
            end
        end
        n_msgs++;
    endtask

    task automatic run_phase(input int ml, input int qb, input int nm, input int quota);
        int lim, r;
        set_limits(ml, qb, nm);
        lim = (ml < qb) ? ml : qb;
        if (lim > 300) lim = 300;
        while (n_items < quota) begin
            r = $urandom_range(0, 9);
            if (r < 7)      feed_message($urandom_range(1, (lim < 8) ? lim : 8), 30);
            else if (r < 9) feed_message($urandom_range(1, (lim < 64) ? lim : 64), 40);
            else            feed_message(lim, 50);
        end
    endtask

    initial begin
        t_status st;
        int pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_limits(4096, 65536, 64);
        send_item(OP_READ, 8'hFF, st);
        feed_message(1, 0);
        send_item(OP_READ, 8'h00, st);
        send_item(OP_READ, 8'h00, st);
        feed_message(3, 0);
        feed_message(2, 0);
        for (int i = 0; i < 5; i++) send_item(OP_READ, 8'($urandom), st);

        run_phase(4096, 65536, 64, 300);
        run_phase(1, 1, 1, 450);
        run_phase(200, 262144, 64, 700);
        run_phase(16, 24, 3, 950);
        run_phase(65536, 524287, 127, 1150);
        no_gaps = 1;
        feed_message(100, 0);
        for (int i = 0; i < 100 + 8; i++) send_item(OP_READ, 8'($urandom), st);
        no_gaps = 0;
        run_phase(4096, 65536, 64, 1450);
        feed_message(5, 0);
        feed_message(2, 0);

        pick = $urandom_range(0, 4);
        case (pick)
            0: for (int i = 0; i < 4; i++) send_item(OP_FEED, 8'h00, st);
            1: begin
                send_item(OP_FEED, 8'h00, st);
                send_item(OP_FEED, 8'h00, st);
                send_item(OP_FEED, 8'h10, st);
                send_item(OP_FEED, 8'h01, st);
            end
            2: send_item(OP_FINISH, 8'($urandom), st);
            3: begin
                send_item(OP_FEED, 8'h00, st);
                send_item(OP_FEED, 8'h00, st);
                send_item(OP_FINISH, 8'($urandom), st);
            end
            default: send_item(OP_CANCEL, 8'($urandom), st);
        endcase
        send_item(OP_FEED, 8'($urandom), st);
        send_item(OP_FINISH, 8'($urandom), st);
        for (int i = 0; i < 9; i++) send_item(OP_READ, 8'($urandom), st);
        send_item(OP_CANCEL, 8'($urandom), st);
        send_item(OP_READ, 8'($urandom), st);
        send_item(OP_FEED, 8'($urandom), st);
        send_item(OP_CANCEL, 8'($urandom), st);

        stim_done = 1;
        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("%0d items sent, %0d messages framed, %0d results checked over six limit sets;",
                 n_items, n_msgs, model.n_checked);
        $display("stream closing case %0d, %0d mismatches", pick, model.mismatches);
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
